/* design/double_ended_queue_assert.svh */
// assertion macros for the double-ended queue, included by dq_ptr
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// same-cycle implication, checked at every rising aclk outside reset
`define DQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked at every rising aclk outside reset
`define DQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/dq_pkg.sv */
// package with codes, field widths and types of the double-ended queue
package dq_pkg;

    localparam int DQ_DEPTH      = 16;
    localparam int DQ_ELEM_WIDTH = 8;

    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 8;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                nonempty;
    } dq_stat_t;

endpackage

/* design/dq_ram.sv */
// element store: one write port, two registered read ports
module dq_ram
    import dq_pkg::*;
#(
    parameter int DEPTH      = DQ_DEPTH,
    parameter int ELEM_WIDTH = DQ_ELEM_WIDTH,
    localparam int AW        = $clog2(DEPTH)
) (
    input  logic                  aclk,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  logic [ELEM_WIDTH-1:0] wdata,
    input  logic                  re,
    input  logic [AW-1:0]         raddr_front,
    input  logic [AW-1:0]         raddr_back,
    output logic [ELEM_WIDTH-1:0] rdata_front,
    output logic [ELEM_WIDTH-1:0] rdata_back
);

    logic [ELEM_WIDTH-1:0] mem [DEPTH];
    logic [ELEM_WIDTH-1:0] rdata_front_reg;
    logic [ELEM_WIDTH-1:0] rdata_back_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_front_reg <= mem[raddr_front];
            rdata_back_reg  <= mem[raddr_back];
        end
    end

    assign rdata_front = rdata_front_reg;
    assign rdata_back  = rdata_back_reg;

endmodule

/* design/dq_ptr.sv */
// head and fill count registers, request decode and ring address arithmetic
module dq_ptr
    import dq_pkg::*;
#(
    parameter int DEPTH      = DQ_DEPTH,
    parameter int ELEM_WIDTH = DQ_ELEM_WIDTH,
    localparam int AW        = $clog2(DEPTH),
    localparam int CW        = $clog2(DEPTH + 1),
    localparam int SW        = CW + 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  go,
    input  logic [ACTION_W-1:0]   action,
    input  logic [VALUE_W-1:0]    value,
    output logic                  we,
    output logic [AW-1:0]         waddr,
    output logic [ELEM_WIDTH-1:0] wdata,
    output logic [AW-1:0]         front_addr,
    output logic [AW-1:0]         back_addr,
    output logic [CW-1:0]         count,
    output dq_stat_t              stat
);

    `include "double_ended_queue_assert.svh"

    logic [AW-1:0]       head_reg;
    logic [AW-1:0]       head_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic                we_next;
    logic [AW-1:0]       waddr_next;
    logic [SW-1:0]       tail_sum;
    logic [AW-1:0]       tail_addr;
    logic [SW-1:0]       last_sum;
    logic [AW-1:0]       last_addr;
    logic [AW-1:0]       head_dec;
    logic [AW-1:0]       head_inc;
    logic                full;
    logic                empty;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    // slot just past the back element
    assign tail_sum  = SW'(head_reg) + SW'(count_reg);
    assign tail_addr = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);

    // slot of the back element
    assign last_sum  = (tail_sum == '0) ? SW'(DEPTH - 1) : tail_sum - 1'b1;
    assign last_addr = (last_sum >= SW'(DEPTH)) ? AW'(last_sum - SW'(DEPTH)) : AW'(last_sum);

    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;

    always_comb begin
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = ST_DONE;
        we_next     = 1'b0;
        waddr_next  = tail_addr;
        case (action)
            ACT_PUSH_BACK: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    we_next    = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            ACT_PUSH_FRONT: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    we_next    = 1'b1;
                    waddr_next = head_dec;
                    head_next  = head_dec;
                    count_next = count_reg + 1'b1;
                end
            end
            ACT_POP_FRONT: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                end
            end
            ACT_POP_BACK: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    count_next = count_reg - 1'b1;
                end
            end
            ACT_CLEAR: begin
                head_next  = '0;
                count_next = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            count_reg  <= '0;
            status_reg <= ST_DONE;
        end else if (go) begin
            head_reg   <= head_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    assign we    = go && we_next;
    assign waddr = waddr_next;
    assign wdata = ELEM_WIDTH'(value);

    assign front_addr    = head_reg;
    assign back_addr     = last_addr;
    assign count         = count_reg;
    assign stat.status   = status_reg;
    assign stat.nonempty = !empty;

    `DQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(DEPTH), "fill count above depth")
    `DQ_ASSERT_NOW(a_write_room, we, !full, "slot written while queue full")
    `DQ_ASSERT_NEXT(a_refused_push, go && full && (action == ACT_PUSH_BACK || action == ACT_PUSH_FRONT), $stable(count_reg) && $stable(head_reg) && status_reg == ST_FULL, "refused push changed the queue")
    `DQ_ASSERT_NEXT(a_pop_front, go && !empty && action == ACT_POP_FRONT, count_reg == $past(count_reg) - 1'b1 && head_reg != $past(head_reg), "pop front did not advance")

endmodule

/* design/double_ended_queue.sv */
// a request is taken in S_IDLE, read in S_READ and loaded into the output register in S_LOAD
// a new request is taken only in S_IDLE, once the last result has been loaded
// the output register holds a result while the next request is taken
// reset: synchronous active-low aresetn empties the queue and drops m_tvalid
// slot contents are not cleared by reset or by a clear request
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH      = DQ_DEPTH,
    parameter int ELEM_WIDTH = DQ_ELEM_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // value[7:0]
    input  logic [2:0]  s_tuser,   // action[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // front_value[7:0], back_value[15:8], count[20:16]
    output logic [3:0]  m_tuser    // front_valid[0], back_valid[1], status[3:2]
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic                  go;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [ELEM_WIDTH-1:0] wdata;
    logic [AW-1:0]         front_addr;
    logic [AW-1:0]         back_addr;
    logic [CW-1:0]         count;
    dq_stat_t              stat;
    logic [ELEM_WIDTH-1:0] rdata_front;
    logic [ELEM_WIDTH-1:0] rdata_back;
    logic                  load;
    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    logic [23:0]           m_tdata_reg;
    logic [3:0]            m_tuser_reg;
    logic [VALUE_W-1:0]    front_out;
    logic [VALUE_W-1:0]    back_out;

    assign s_tready = (state_reg == S_IDLE);
    assign go       = s_tvalid && s_tready;
    assign load     = (state_reg == S_LOAD) && (!m_tvalid_reg || m_tready);

    dq_ptr #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_ptr (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .go         (go),
        .action     (s_tuser),
        .value      (s_tdata),
        .we         (we),
        .waddr      (waddr),
        .wdata      (wdata),
        .front_addr (front_addr),
        .back_addr  (back_addr),
        .count      (count),
        .stat       (stat)
    );

    dq_ram #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_ram (
        .aclk        (aclk),
        .we          (we),
        .waddr       (waddr),
        .wdata       (wdata),
        .re          (state_reg == S_READ),
        .raddr_front (front_addr),
        .raddr_back  (back_addr),
        .rdata_front (rdata_front),
        .rdata_back  (rdata_back)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (go) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_LOAD;
            end
            S_LOAD: begin
                if (load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign front_out = stat.nonempty ? VALUE_W'(rdata_front) : '0;
    assign back_out  = stat.nonempty ? VALUE_W'(rdata_back) : '0;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= {3'b000, COUNT_W'(count), back_out, front_out};
            m_tuser_reg <= {stat.status, stat.nonempty, stat.nonempty};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
